FILE: hw/rtl/brc_pkg.sv
`default_nettype none

package brc_pkg;

    // Internal coordinate width: holds every sum and delta of the clip math
    localparam int CW = 20;

    typedef logic signed [CW-1:0] coord_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_REGION_LEFT   = 2'd0,
        REG_REGION_TOP    = 2'd1,
        REG_REGION_WIDTH  = 2'd2,
        REG_REGION_HEIGHT = 2'd3
    } reg_idx_t;

    // One blit command as it enters the block
    typedef struct packed {
        logic signed [15:0] dest_left;
        logic signed [15:0] dest_top;
        logic [14:0]        dest_width;
        logic [14:0]        dest_height;
        logic signed [15:0] source_left;
        logic signed [15:0] source_top;
        logic signed [15:0] source_width;
        logic signed [15:0] source_height;
    } cmd_t;

    // Sign-extend a 16-bit coordinate
    function automatic coord_t sx16(input logic [15:0] v);
        return {{(CW-16){v[15]}}, v};
    endfunction

    // Zero-extend a 15-bit size
    function automatic coord_t zx15(input logic [14:0] v);
        return {{(CW-15){1'b0}}, v};
    endfunction

    // Saturate to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input coord_t v);
        logic signed [15:0] r;
        if (v < sx16(16'h8000)) begin
            r = 16'sh8000;
        end
        else if (v > sx16(16'h7fff)) begin
            r = 16'sh7fff;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/blit_rect_clipper.sv
// Channel   Handshake              Payload
// -------   --------------------   ---------------------------------------------
// config    cfg_wr_en              cfg_index, cfg_data
// in        in_valid / in_stall    dest_*, source_*
// out       out_valid / out_stall  visible, was_clipped, out_dest_*, out_source_*
//
// Five register stages; one command per cycle while the output is not stalled.
// Depth is set by the chain add, compare/clamp, size, delta, saturate.
// Reset clears the stage valid bits and the region registers (empty region).
// A stage moves when it is empty or the stage after it moves; a stalled output holds
// each full stage behind it, bubbles collapse, in_stall rises only when all are full.
`default_nettype none

module blit_rect_clipper
    import brc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] dest_left,
    input  wire logic signed [15:0] dest_top,
    input  wire logic [14:0]        dest_width,
    input  wire logic [14:0]        dest_height,
    input  wire logic signed [15:0] source_left,
    input  wire logic signed [15:0] source_top,
    input  wire logic signed [15:0] source_width,
    input  wire logic signed [15:0] source_height,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    visible,
    output logic                    was_clipped,
    output logic signed [15:0]      out_dest_left,
    output logic signed [15:0]      out_dest_top,
    output logic [14:0]             out_dest_width,
    output logic [14:0]             out_dest_height,
    output logic signed [15:0]      out_source_left,
    output logic signed [15:0]      out_source_top,
    output logic signed [15:0]      out_source_width,
    output logic signed [15:0]      out_source_height
);

    typedef struct packed {
        cmd_t   cmd;
        coord_t rx2m1;
        coord_t ry2m1;
        coord_t dx2m1;
        coord_t dy2m1;
        logic   nz;
    } s1_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   vis;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } s2_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   vis;
        coord_t nl;
        coord_t nt;
        coord_t nw;
        coord_t nh;
        coord_t dxd;
        coord_t dyd;
    } s3_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   vis;
        logic   clipped;
        coord_t nl;
        coord_t nt;
        coord_t nw;
        coord_t nh;
        coord_t sum_l;
        coord_t sum_t;
        coord_t dwd;
        coord_t dhd;
    } s4_t;

    typedef struct packed {
        logic               vis;
        logic               clipped;
        logic signed [15:0] dl;
        logic signed [15:0] dt;
        logic [14:0]        dw;
        logic [14:0]        dh;
        logic signed [15:0] sl;
        logic signed [15:0] st;
        logic signed [15:0] sw;
        logic signed [15:0] sh;
    } s5_t;

    logic signed [15:0] region_left_reg;
    logic signed [15:0] region_top_reg;
    logic [14:0]        region_width_reg;
    logic [14:0]        region_height_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    cmd_t   cmd_in;
    coord_t rleft;
    coord_t rtop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_width_reg  <= '0;
            region_height_reg <= '0;
        end
        else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REGION_LEFT:   region_left_reg   <= cfg_data;
                REG_REGION_TOP:    region_top_reg    <= cfg_data;
                REG_REGION_WIDTH:  region_width_reg  <= cfg_data[14:0];
                REG_REGION_HEIGHT: region_height_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign rleft = sx16(region_left_reg);
    assign rtop  = sx16(region_top_reg);

    // Advance a stage when it is empty or the next one advances
    assign en5      = !v5_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: far edges of region and destination
    always_comb begin
        cmd_in.dest_left     = dest_left;
        cmd_in.dest_top      = dest_top;
        cmd_in.dest_width    = dest_width;
        cmd_in.dest_height   = dest_height;
        cmd_in.source_left   = source_left;
        cmd_in.source_top    = source_top;
        cmd_in.source_width  = source_width;
        cmd_in.source_height = source_height;

        s1_next.cmd   = cmd_in;
        s1_next.rx2m1 = rleft + zx15(region_width_reg) - coord_t'(1);
        s1_next.ry2m1 = rtop + zx15(region_height_reg) - coord_t'(1);
        s1_next.dx2m1 = sx16(dest_left) + zx15(dest_width) - coord_t'(1);
        s1_next.dy2m1 = sx16(dest_top) + zx15(dest_height) - coord_t'(1);
        s1_next.nz    = (dest_width != '0) && (dest_height != '0) &&
                        (region_width_reg != '0) && (region_height_reg != '0);
    end

    // Stage 2: overlap test and corner clamps
    always_comb begin
        coord_t dl;
        coord_t dt;
        dl = sx16(s1_reg.cmd.dest_left);
        dt = sx16(s1_reg.cmd.dest_top);

        s2_next.cmd = s1_reg.cmd;
        s2_next.vis = s1_reg.nz && (dl <= s1_reg.rx2m1) && (dt <= s1_reg.ry2m1) &&
                      (s1_reg.dx2m1 >= rleft) && (s1_reg.dy2m1 >= rtop);

        if (dl < rleft)              s2_next.x1 = rleft;
        else if (dl > s1_reg.rx2m1)  s2_next.x1 = s1_reg.rx2m1;
        else                         s2_next.x1 = dl;

        if (dt < rtop)               s2_next.y1 = rtop;
        else if (dt > s1_reg.ry2m1)  s2_next.y1 = s1_reg.ry2m1;
        else                         s2_next.y1 = dt;

        if (s1_reg.dx2m1 < rleft)             s2_next.x2 = rleft;
        else if (s1_reg.dx2m1 > s1_reg.rx2m1) s2_next.x2 = s1_reg.rx2m1;
        else                                  s2_next.x2 = s1_reg.dx2m1;

        if (s1_reg.dy2m1 < rtop)              s2_next.y2 = rtop;
        else if (s1_reg.dy2m1 > s1_reg.ry2m1) s2_next.y2 = s1_reg.ry2m1;
        else                                  s2_next.y2 = s1_reg.dy2m1;
    end

    // Stage 3: new size and origin deltas
    always_comb begin
        s3_next.cmd = s2_reg.cmd;
        s3_next.vis = s2_reg.vis;
        s3_next.nl  = s2_reg.x1;
        s3_next.nt  = s2_reg.y1;
        s3_next.nw  = s2_reg.x2 - s2_reg.x1 + coord_t'(1);
        s3_next.nh  = s2_reg.y2 - s2_reg.y1 + coord_t'(1);
        s3_next.dxd = s2_reg.x1 - sx16(s2_reg.cmd.dest_left);
        s3_next.dyd = s2_reg.y1 - sx16(s2_reg.cmd.dest_top);
    end

    // Stage 4: change flag, size deltas, shifted source origin
    always_comb begin
        s4_next.cmd     = s3_reg.cmd;
        s4_next.vis     = s3_reg.vis;
        s4_next.nl      = s3_reg.nl;
        s4_next.nt      = s3_reg.nt;
        s4_next.nw      = s3_reg.nw;
        s4_next.nh      = s3_reg.nh;
        s4_next.clipped = s3_reg.vis &&
                          !((s3_reg.nl == sx16(s3_reg.cmd.dest_left)) &&
                            (s3_reg.nt == sx16(s3_reg.cmd.dest_top)) &&
                            (s3_reg.nw == zx15(s3_reg.cmd.dest_width)) &&
                            (s3_reg.nh == zx15(s3_reg.cmd.dest_height)));
        s4_next.sum_l   = sx16(s3_reg.cmd.source_left) + s3_reg.dxd;
        s4_next.sum_t   = sx16(s3_reg.cmd.source_top) + s3_reg.dyd;
        s4_next.dwd     = s3_reg.nw - zx15(s3_reg.cmd.dest_width);
        s4_next.dhd     = s3_reg.nh - zx15(s3_reg.cmd.dest_height);
    end

    // Stage 5: saturate source and select pass-through values
    always_comb begin
        s5_next.vis     = s4_reg.vis;
        s5_next.clipped = s4_reg.clipped;
        if (s4_reg.vis) begin
            s5_next.dl = s4_reg.nl[15:0];
            s5_next.dt = s4_reg.nt[15:0];
            s5_next.dw = s4_reg.nw[14:0];
            s5_next.dh = s4_reg.nh[14:0];
        end
        else begin
            s5_next.dl = s4_reg.cmd.dest_left;
            s5_next.dt = s4_reg.cmd.dest_top;
            s5_next.dw = s4_reg.cmd.dest_width;
            s5_next.dh = s4_reg.cmd.dest_height;
        end
        if (s4_reg.clipped) begin
            s5_next.sl = sat16(s4_reg.sum_l);
            s5_next.st = sat16(s4_reg.sum_t);
            s5_next.sw = sat16(sx16(s4_reg.cmd.source_width) + s4_reg.dwd);
            s5_next.sh = sat16(sx16(s4_reg.cmd.source_height) + s4_reg.dhd);
        end
        else begin
            s5_next.sl = s4_reg.cmd.source_left;
            s5_next.st = s4_reg.cmd.source_top;
            s5_next.sw = s4_reg.cmd.source_width;
            s5_next.sh = s4_reg.cmd.source_height;
        end
    end

    // Hold payload while a stage is blocked
    always_ff @(posedge clk) begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4) s4_reg <= s4_next;
        if (en5) s5_reg <= s5_next;
    end

    assign out_valid         = v5_reg;
    assign visible           = s5_reg.vis;
    assign was_clipped       = s5_reg.clipped;
    assign out_dest_left     = s5_reg.dl;
    assign out_dest_top      = s5_reg.dt;
    assign out_dest_width    = s5_reg.dw;
    assign out_dest_height   = s5_reg.dh;
    assign out_source_left   = s5_reg.sl;
    assign out_source_top    = s5_reg.st;
    assign out_source_width  = s5_reg.sw;
    assign out_source_height = s5_reg.sh;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_stall))
        else $error("input stalled with room in the pipe");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted beat lost at stage 1");

    a_culled_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> !was_clipped)
        else $error("culled command flagged as clipped");

    a_visible_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (out_dest_width != '0 && out_dest_height != '0))
        else $error("visible command with empty destination");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && v5_reg && out_stall) |=> v4_reg)
        else $error("stage 4 beat dropped behind a stalled output");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
module tb;
    import brc_pkg::*;

    // One clipped command as it leaves the block
    typedef struct packed {
        logic               visible;
        logic               was_clipped;
        logic signed [15:0] dest_left;
        logic signed [15:0] dest_top;
        logic [14:0]        dest_width;
        logic [14:0]        dest_height;
        logic signed [15:0] source_left;
        logic signed [15:0] source_top;
        logic signed [15:0] source_width;
        logic signed [15:0] source_height;
    } clip_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    reg_idx_t           cfg_index = REG_REGION_LEFT;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    cmd_t               cmd_bus = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               visible;
    logic               was_clipped;
    logic signed [15:0] out_dest_left;
    logic signed [15:0] out_dest_top;
    logic [14:0]        out_dest_width;
    logic [14:0]        out_dest_height;
    logic signed [15:0] out_source_left;
    logic signed [15:0] out_source_top;
    logic signed [15:0] out_source_width;
    logic signed [15:0] out_source_height;

    // Local copy of the canvas region registers
    int region_left = 0;
    int region_top = 0;
    int region_width = 0;
    int region_height = 0;

    cmd_t         pending_cmds[$];
    clip_result_t expected_clips[$];
    clip_result_t oldest_clip;
    int           error_count = 0;
    bit           calm = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           run_left = 0;

    blit_rect_clipper dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .dest_left         (cmd_bus.dest_left),
        .dest_top          (cmd_bus.dest_top),
        .dest_width        (cmd_bus.dest_width),
        .dest_height       (cmd_bus.dest_height),
        .source_left       (cmd_bus.source_left),
        .source_top        (cmd_bus.source_top),
        .source_width      (cmd_bus.source_width),
        .source_height     (cmd_bus.source_height),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .visible           (visible),
        .was_clipped       (was_clipped),
        .out_dest_left     (out_dest_left),
        .out_dest_top      (out_dest_top),
        .out_dest_width    (out_dest_width),
        .out_dest_height   (out_dest_height),
        .out_source_left   (out_source_left),
        .out_source_top    (out_source_top),
        .out_source_width  (out_source_width),
        .out_source_height (out_source_height)
    );

    always #1 clk = ~clk;

    function automatic int clamp_int(int lo, int v, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic signed [15:0] sat_int(int v);
        if (v < -32768)
            return 16'sh8000;
        if (v > 32767)
            return 16'sh7fff;
        return v[15:0];
    endfunction

    // Clip one command against the current region
    function automatic clip_result_t clip_command(cmd_t c);
        int dl, dt, dw, dh, rx2, ry2, dx2, dy2, nl, nt, nw, nh;
        clip_result_t r;
        dl = int'($signed(c.dest_left));
        dt = int'($signed(c.dest_top));
        dw = int'({17'd0, c.dest_width});
        dh = int'({17'd0, c.dest_height});
        rx2 = region_left + region_width;
        ry2 = region_top + region_height;
        dx2 = dl + dw;
        dy2 = dt + dh;
        r.visible = 1'b0;
        r.was_clipped = 1'b0;
        r.dest_left = c.dest_left;
        r.dest_top = c.dest_top;
        r.dest_width = c.dest_width;
        r.dest_height = c.dest_height;
        r.source_left = c.source_left;
        r.source_top = c.source_top;
        r.source_width = c.source_width;
        r.source_height = c.source_height;
        // spans are half open and must overlap on both axes
        if (dw > 0 && dh > 0 && region_width > 0 && region_height > 0 &&
            dl < rx2 && dt < ry2 && dx2 > region_left && dy2 > region_top)
        begin
            nl = clamp_int(region_left, dl, rx2 - 1);
            nt = clamp_int(region_top, dt, ry2 - 1);
            nw = clamp_int(region_left, dx2 - 1, rx2 - 1) - nl + 1;
            nh = clamp_int(region_top, dy2 - 1, ry2 - 1) - nt + 1;
            r.visible = 1'b1;
            r.dest_left = nl[15:0];
            r.dest_top = nt[15:0];
            r.dest_width = nw[14:0];
            r.dest_height = nh[14:0];
            // shift the source by the same deltas, saturated
            if (nl != dl || nt != dt || nw != dw || nh != dh)
            begin
                r.was_clipped = 1'b1;
                r.source_left = sat_int(int'($signed(c.source_left)) + nl - dl);
                r.source_top = sat_int(int'($signed(c.source_top)) + nt - dt);
                r.source_width = sat_int(int'($signed(c.source_width)) + nw - dw);
                r.source_height = sat_int(int'($signed(c.source_height)) + nh - dh);
            end
        end
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    // Bias toward the ends of the signed range to hit saturation
    function automatic logic [15:0] edgy16();
        int roll;
        logic [15:0] v;
        roll = $urandom_range(5);
        v = rand16();
        if (roll == 0)
            return 16'h7fff - {12'd0, v[3:0]};
        if (roll == 1)
            return 16'h8000 + {12'd0, v[3:0]};
        return v;
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int dw, dh, dl, dt, lim;
        logic [15:0] r;
        if ($urandom_range(9) < 7)
        begin
            // place the destination around the region edges
            lim = 2 * region_width + 32;
            if (lim > 32767)
                lim = 32767;
            dw = $urandom_range(lim);
            lim = 2 * region_height + 32;
            if (lim > 32767)
                lim = 32767;
            dh = $urandom_range(lim);
            dl = region_left - dw - 8 + int'($urandom_range(region_width + dw + 16));
            dt = region_top - dh - 8 + int'($urandom_range(region_height + dh + 16));
            c.dest_left = dl[15:0];
            c.dest_top = dt[15:0];
            c.dest_width = dw[14:0];
            c.dest_height = dh[14:0];
            c.source_left = edgy16();
            c.source_top = edgy16();
            c.source_width = edgy16();
            c.source_height = edgy16();
        end
        else
        begin
            c.dest_left = rand16();
            c.dest_top = rand16();
            r = rand16();
            c.dest_width = r[14:0];
            r = rand16();
            c.dest_height = r[14:0];
            c.source_left = rand16();
            c.source_top = rand16();
            c.source_width = rand16();
            c.source_height = rand16();
        end
        return c;
    endfunction

    task automatic queue_cmd(int dl, int dt, int dw, int dh,
                             int sl, int st, int sw, int sh);
        cmd_t c;
        c.dest_left = dl[15:0];
        c.dest_top = dt[15:0];
        c.dest_width = dw[14:0];
        c.dest_height = dh[14:0];
        c.source_left = sl[15:0];
        c.source_top = st[15:0];
        c.source_width = sw[15:0];
        c.source_height = sh[15:0];
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic write_region(reg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_REGION_LEFT:   region_left = int'($signed(value));
            REG_REGION_TOP:    region_top = int'($signed(value));
            REG_REGION_WIDTH:  region_width = int'({17'd0, value[14:0]});
            REG_REGION_HEIGHT: region_height = int'({17'd0, value[14:0]});
            default: ;
        endcase
    endtask

    task automatic set_region(int l, int t, int w, int h);
        write_region(REG_REGION_LEFT, l[15:0]);
        write_region(REG_REGION_TOP, t[15:0]);
        write_region(REG_REGION_WIDTH, w[15:0]);
        write_region(REG_REGION_HEIGHT, h[15:0]);
    endtask

    // Wait for every beat to go in and every result to come out, then drain
    task automatic settle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_clips.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    // Driver: offer queued commands, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_clips.push_back(clip_command(cmd_bus));
            // advance once the current beat is gone
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_bus <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    send_gap = calm ? 0 : idle_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, drive the stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_clips.size() == 0)
                begin
                    report_mismatch("result beat with no command outstanding");
                end
                else
                begin
                    oldest_clip = expected_clips.pop_front();
                    check_field("visible", {15'd0, visible}, {15'd0, oldest_clip.visible});
                    check_field("was_clipped", {15'd0, was_clipped},
                                {15'd0, oldest_clip.was_clipped});
                    check_field("dest_left", out_dest_left, oldest_clip.dest_left);
                    check_field("dest_top", out_dest_top, oldest_clip.dest_top);
                    check_field("dest_width", {1'b0, out_dest_width},
                                {1'b0, oldest_clip.dest_width});
                    check_field("dest_height", {1'b0, out_dest_height},
                                {1'b0, oldest_clip.dest_height});
                    check_field("source_left", out_source_left, oldest_clip.source_left);
                    check_field("source_top", out_source_top, oldest_clip.source_top);
                    check_field("source_width", out_source_width, oldest_clip.source_width);
                    check_field("source_height", out_source_height,
                                oldest_clip.source_height);
                end
            end
            // alternate free runs and stalls
            if (calm)
            begin
                out_stall <= 1'b0;
                stall_left = 0;
                run_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_stall <= 1'b0;
                run_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(8);
                stall_left = idle_length();
            end
        end
    end

    initial
    begin
        int round;
        int k;
        int count;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty region after reset culls everything
        queue_cmd(0, 0, 10, 10, 1, 2, 3, 4);
        queue_cmd(-32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767);
        settle();

        // region spans x -100..99, y 50..149
        set_region(-100, 50, 200, 100);
        queue_cmd(-50, 60, 20, 20, 5, 6, 20, 20);
        queue_cmd(-100, 50, 200, 100, 0, 0, 200, 100);
        queue_cmd(-120, 60, 40, 10, 10, 10, 40, 10);
        queue_cmd(90, 60, 30, 10, 10, 10, 30, 10);
        queue_cmd(0, 40, 10, 20, 10, 10, 10, 20);
        queue_cmd(0, 140, 10, 20, 10, 10, 10, 20);
        queue_cmd(-1000, -1000, 5000, 5000, 0, 0, 5000, 5000);
        queue_cmd(-110, 60, 10, 10, 1, 1, 1, 1);
        queue_cmd(100, 60, 10, 10, 1, 1, 1, 1);
        queue_cmd(0, 40, 10, 10, 1, 1, 1, 1);
        queue_cmd(0, 150, 5, 5, 1, 1, 1, 1);
        queue_cmd(0, 60, 0, 10, 1, 1, 1, 1);
        queue_cmd(0, 60, 10, 0, 1, 1, 1, 1);
        queue_cmd(-120, 40, 40, 20, 32767, 32760, -32768, -32768);
        queue_cmd(99, 149, 5, 5, -7, -8, 9, 10);
        queue_cmd(32767, 32767, 32767, 32767, 3, 3, 3, 3);
        queue_cmd(-32768, 60, 32767, 10, -32768, 0, 32767, 10);
        settle();

        // region at the top of the coordinate range
        set_region(32767, 32767, 32767, 32767);
        queue_cmd(32767, 32767, 1, 1, 0, 0, 1, 1);
        queue_cmd(32760, 32760, 100, 100, 32767, 0, -32768, 100);
        queue_cmd(0, 0, 32767, 32767, 0, 0, 0, 0);
        settle();

        // region at the bottom of the coordinate range
        set_region(-32768, -32768, 32767, 32767);
        queue_cmd(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
        queue_cmd(0, 0, 10, 10, 0, 0, 0, 0);
        queue_cmd(-20, -20, 30, 30, 32767, 32767, -32768, -32768);
        settle();

        // random commands over a series of region settings
        for (round = 0; round < 8; round++)
        begin
            count = 115;
            calm = 1'b0;
            case (round)
                0: set_region(0, 0, 32'hffff, 32'hffff);
                1: set_region(int'(rand16()), int'(rand16()), int'(rand16()), int'(rand16()));
                2: set_region(int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20,
                              1, 1);
                3:
                begin
                    set_region(-50, -50, 0, 100);
                    count = 40;
                end
                4:
                begin
                    set_region(int'(rand16()), int'(rand16()), int'(rand16()),
                               int'(rand16()));
                    calm = 1'b1;
                end
                5: set_region(-32768, -32768, 32767, 32767);
                6: set_region(int'(rand16()), int'(rand16()), int'(rand16()), int'(rand16()));
                default: set_region(-500, -300, 1000, 600);
            endcase
            for (k = 0; k < count; k++)
                pending_cmds.push_back(random_command());
            settle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
